>>> hw/rtl/mmdm_pkg.sv
// Shared constants, codes and control types of the min-match disjunction merge.
package mmdm_pkg;

    localparam int LISTS          = 16;
    localparam int ID_W           = 4;
    localparam int CNT_W          = 5;
    localparam int SUM_W          = 20;
    localparam int CFG_W          = 5;
    localparam int CFG_IDX_W      = 1;
    localparam int KIND_W         = 2;
    localparam int DOC_BITS_DEF   = 31;
    localparam int SCORE_BITS_DEF = 16;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MATCH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_COUNT = 1'd1;

    localparam logic [CNT_W-1:0] MIN_MATCH_RST  = 5'd1;
    localparam logic [CNT_W-1:0] LIST_COUNT_RST = 5'd2;
    localparam logic [CNT_W-1:0] LISTS_CNT      = 5'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQ   = 2'd0,
        KIND_MATCH = 2'd1,
        KIND_FIN   = 2'd2
    } t_kind;

    typedef struct packed {
        logic  load_item;
        logic  merge_item;
        logic  scan_init;
        logic  scan_step;
        logic  load_out;
        t_kind out_kind;
    } t_cmd;

    typedef struct packed {
        logic load_done;
        logic take_ok;
        logic pend_any;
        logic match_ok;
        logic finish;
        logic scan_last;
    } t_sts;

endpackage

>>> hw/rtl/mmdm_dp.sv
// Datapath: list heads, live bits, counters, candidate scan and the result register.
module mmdm_dp #(
    parameter int DOC_BITS   = mmdm_pkg::DOC_BITS_DEF,
    parameter int SCORE_BITS = mmdm_pkg::SCORE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mmdm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mmdm_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_kind,
    input  logic [mmdm_pkg::ID_W-1:0]         i_id,
    input  logic [DOC_BITS-1:0]               i_doc,
    input  logic [SCORE_BITS-1:0]             i_score,
    input  mmdm_pkg::t_cmd                    i_cmd,
    output mmdm_pkg::t_sts                    o_sts,
    output mmdm_pkg::t_kind                   o_out_kind,
    output logic [mmdm_pkg::ID_W-1:0]         o_out_id,
    output logic [DOC_BITS-1:0]               o_out_doc,
    output logic [mmdm_pkg::SUM_W-1:0]        o_out_sum,
    output logic [mmdm_pkg::CNT_W-1:0]        o_out_cnt
);

    localparam int LISTS = mmdm_pkg::LISTS;
    localparam int ID_W  = mmdm_pkg::ID_W;
    localparam int CNT_W = mmdm_pkg::CNT_W;
    localparam int SUM_W = mmdm_pkg::SUM_W;
    localparam int ADD_W = ((SCORE_BITS > SUM_W) ? SCORE_BITS : SUM_W) + 1;

    logic [CNT_W-1:0]      r_min_match;
    logic [CNT_W-1:0]      r_list_count;
    logic [DOC_BITS-1:0]   r_head_doc   [LISTS];
    logic [SCORE_BITS-1:0] r_head_score [LISTS];
    logic [LISTS-1:0]      r_alive;
    logic [CNT_W-1:0]      r_alive_cnt;
    logic [CNT_W-1:0]      r_loaded_cnt;
    logic [LISTS-1:0]      r_pend;
    logic [DOC_BITS-1:0]   r_cur_doc;
    logic [SUM_W-1:0]      r_cur_sum;
    logic [CNT_W-1:0]      r_cur_cnt;
    logic                  r_found;
    logic [ID_W-1:0]       r_idx;
    mmdm_pkg::t_kind       r_out_kind;
    logic [ID_W-1:0]       r_out_id;
    logic [DOC_BITS-1:0]   r_out_doc;
    logic [SUM_W-1:0]      r_out_sum;
    logic [CNT_W-1:0]      r_out_cnt;

    logic [CNT_W-1:0]      w_eff;
    logic                  w_id_in;
    logic [ID_W-1:0]       w_low;
    logic                  w_take_ok;
    logic                  w_take;
    logic                  w_load;
    logic [DOC_BITS-1:0]   w_hd;
    logic [SCORE_BITS-1:0] w_hs;
    logic                  w_new_min;
    logic                  w_same;
    logic [LISTS-1:0]      w_idx_bit;
    logic [LISTS-1:0]      w_id_bit;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SCORE_BITS-1:0] b);
        logic [ADD_W-1:0] s;
        s = ADD_W'(a) + ADD_W'(b);
        if (s > ADD_W'(mmdm_pkg::SUM_MAX)) begin
            sat_add = mmdm_pkg::SUM_MAX;
        end else begin
            sat_add = s[SUM_W-1:0];
        end
    endfunction

    always_comb begin
        w_low = '0;
        for (int i = LISTS - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                w_low = ID_W'(i);
            end
        end
    end

    assign w_eff     = (r_list_count > mmdm_pkg::LISTS_CNT) ? mmdm_pkg::LISTS_CNT : r_list_count;
    assign w_id_in   = {{(CNT_W-ID_W){1'b0}}, i_id} < w_eff;
    assign w_id_bit  = {{(LISTS-1){1'b0}}, 1'b1} << i_id;
    assign w_idx_bit = {{(LISTS-1){1'b0}}, 1'b1} << r_idx;
    assign w_take_ok = (r_pend != '0) && (i_id == w_low);
    assign w_take    = i_cmd.merge_item && w_take_ok;
    assign w_load    = i_cmd.load_item && w_id_in && !r_pend[i_id];
    assign w_hd      = r_head_doc[r_idx];
    assign w_hs      = r_head_score[r_idx];
    assign w_new_min = r_alive[r_idx] && (!r_found || (w_hd < r_cur_doc));
    assign w_same    = r_alive[r_idx] && r_found && (w_hd == r_cur_doc);

    assign o_sts.load_done = r_loaded_cnt >= w_eff;
    assign o_sts.take_ok   = w_take_ok;
    assign o_sts.pend_any  = r_pend != '0;
    assign o_sts.match_ok  = r_cur_cnt >= r_min_match;
    assign o_sts.finish    = (r_alive_cnt == '0) || (r_alive_cnt < r_min_match);
    assign o_sts.scan_last = r_idx == ID_W'(LISTS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_match  <= mmdm_pkg::MIN_MATCH_RST;
            r_list_count <= mmdm_pkg::LIST_COUNT_RST;
            r_alive      <= '0;
            r_alive_cnt  <= '0;
            r_loaded_cnt <= '0;
            r_pend       <= '0;
            r_found      <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mmdm_pkg::CFG_MIN_MATCH:  r_min_match  <= i_cfg_data;
                    mmdm_pkg::CFG_LIST_COUNT: r_list_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_load) begin
                r_pend       <= r_pend | w_id_bit;
                r_loaded_cnt <= r_loaded_cnt + 1'b1;
                if (!i_kind) begin
                    r_alive     <= r_alive | w_id_bit;
                    r_alive_cnt <= r_alive_cnt + 1'b1;
                end
            end
            if (w_take) begin
                r_pend <= r_pend & ~w_id_bit;
                if (i_kind) begin
                    r_alive <= r_alive & ~w_id_bit;
                    if (r_alive[i_id] && (r_alive_cnt != '0)) begin
                        r_alive_cnt <= r_alive_cnt - 1'b1;
                    end
                end
            end
            if (i_cmd.scan_init) begin
                r_pend  <= '0;
                r_found <= 1'b0;
                r_idx   <= '0;
            end
            if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
                if (w_new_min) begin
                    r_found <= 1'b1;
                    r_pend  <= w_idx_bit;
                end else if (w_same) begin
                    r_pend <= r_pend | w_idx_bit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_load || w_take) && !i_kind) begin
            r_head_doc[i_id]   <= i_doc;
            r_head_score[i_id] <= i_score;
        end
        if (i_cmd.scan_step) begin
            if (w_new_min) begin
                r_cur_doc <= w_hd;
                r_cur_sum <= sat_add('0, w_hs);
                r_cur_cnt <= CNT_W'(1);
            end else if (w_same) begin
                r_cur_sum <= sat_add(r_cur_sum, w_hs);
                r_cur_cnt <= r_cur_cnt + 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out_kind <= i_cmd.out_kind;
            case (i_cmd.out_kind)
                mmdm_pkg::KIND_REQ: begin
                    r_out_id  <= w_low;
                    r_out_doc <= '0;
                    r_out_sum <= '0;
                    r_out_cnt <= '0;
                end
                mmdm_pkg::KIND_MATCH: begin
                    r_out_id  <= '0;
                    r_out_doc <= r_cur_doc;
                    r_out_sum <= r_cur_sum;
                    r_out_cnt <= r_cur_cnt;
                end
                default: begin
                    r_out_id  <= '0;
                    r_out_doc <= '0;
                    r_out_sum <= '0;
                    r_out_cnt <= '0;
                end
            endcase
        end
    end

    assign o_out_kind = r_out_kind;
    assign o_out_id   = r_out_id;
    assign o_out_doc  = r_out_doc;
    assign o_out_sum  = r_out_sum;
    assign o_out_cnt  = r_out_cnt;

endmodule

>>> hw/rtl/mmdm_ctrl.sv
// Controller: sequencing of loading, candidate scans, requests and the output handshake.
module mmdm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_m_tready,
    input  mmdm_pkg::t_sts i_sts,
    output mmdm_pkg::t_cmd o_cmd,
    output logic           o_s_tready,
    output logic           o_m_tvalid
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_LCHK,
        S_START,
        S_SCAN,
        S_REQ,
        S_MERGE,
        S_MCHK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;
    logic   w_free;
    logic   w_acc;

    assign o_s_tready = (r_state == S_LOAD) || (r_state == S_MERGE) || (r_state == S_DONE);
    assign w_free     = !r_m_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.out_kind = mmdm_pkg::KIND_REQ;
        n_state        = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_LCHK;
                end
            end
            S_LCHK: begin
                n_state = i_sts.load_done ? S_START : S_LOAD;
            end
            S_START: begin
                if (i_sts.finish) begin
                    if (w_free) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.out_kind = mmdm_pkg::KIND_FIN;
                        n_state        = S_DONE;
                    end
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_REQ;
                end
            end
            S_REQ: begin
                if (w_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_MERGE;
                end
            end
            S_MERGE: begin
                if (w_acc) begin
                    o_cmd.merge_item = 1'b1;
                    if (i_sts.take_ok) begin
                        n_state = S_MCHK;
                    end
                end
            end
            S_MCHK: begin
                if (i_sts.pend_any) begin
                    if (w_free) begin
                        o_cmd.load_out = 1'b1;
                        n_state        = S_MERGE;
                    end
                end else if (i_sts.match_ok) begin
                    if (w_free) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.out_kind = mmdm_pkg::KIND_MATCH;
                        n_state        = S_START;
                    end
                end else begin
                    n_state = S_START;
                end
            end
            S_DONE: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_DONE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (o_cmd.load_out) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_tvalid = r_m_valid;

endmodule

>>> hw/rtl/min_match_disjunction_merge.sv
// Top level of the min-match disjunction merge of up to sixteen ascending posting lists.
// Each loading word is followed by a load check; each answer to a request by a merge check.
// A new candidate adds a scan of all sixteen list heads plus set-up.
// The scan over the stored heads sets the rate of emitted documents.
// Reset (synchronous, active low) clears the live and pending bits and the alive and loaded counters; no clearing pass.
module min_match_disjunction_merge #(
    parameter int DOC_BITS   = mmdm_pkg::DOC_BITS_DEF,
    parameter int SCORE_BITS = mmdm_pkg::SCORE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // list_id, doc, score
    input  logic [((mmdm_pkg::ID_W + DOC_BITS + SCORE_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    // kind
    input  logic [0:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // list_id_res, doc_res, score_sum, match_count
    output logic [((mmdm_pkg::ID_W + DOC_BITS + mmdm_pkg::SUM_W + mmdm_pkg::CNT_W + 7) / 8)
                  * 8 - 1:0]               o_m_tdata,
    // kind_res
    output logic [mmdm_pkg::KIND_W-1:0]    o_m_tuser,
    input  logic                           i_cfg_we,
    input  logic [mmdm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mmdm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int ID_W  = mmdm_pkg::ID_W;
    localparam int OUT_W = ((ID_W + DOC_BITS + mmdm_pkg::SUM_W + mmdm_pkg::CNT_W + 7) / 8) * 8;

    mmdm_pkg::t_cmd                w_cmd;
    mmdm_pkg::t_sts                w_sts;
    mmdm_pkg::t_kind               w_out_kind;
    logic [ID_W-1:0]               w_out_id;
    logic [DOC_BITS-1:0]           w_out_doc;
    logic [mmdm_pkg::SUM_W-1:0]    w_out_sum;
    logic [mmdm_pkg::CNT_W-1:0]    w_out_cnt;

    mmdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid)
    );

    mmdm_dp #(
        .DOC_BITS   (DOC_BITS),
        .SCORE_BITS (SCORE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_kind     (i_s_tuser[0]),
        .i_id       (i_s_tdata[ID_W-1:0]),
        .i_doc      (i_s_tdata[ID_W+DOC_BITS-1:ID_W]),
        .i_score    (i_s_tdata[ID_W+DOC_BITS+SCORE_BITS-1:ID_W+DOC_BITS]),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out_kind (w_out_kind),
        .o_out_id   (w_out_id),
        .o_out_doc  (w_out_doc),
        .o_out_sum  (w_out_sum),
        .o_out_cnt  (w_out_cnt)
    );

    assign o_m_tdata = OUT_W'({w_out_cnt, w_out_sum, w_out_doc, w_out_id});
    assign o_m_tuser = w_out_kind;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("result register loaded while a word is still waiting");

    a_silent_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && (o_m_tuser == mmdm_pkg::KIND_FIN)) |=> !o_m_tvalid)
        else $error("word produced after the finished word");

    a_match_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == mmdm_pkg::KIND_MATCH))
            |-> (o_m_tdata[ID_W+DOC_BITS+mmdm_pkg::SUM_W+mmdm_pkg::CNT_W-1:
                           ID_W+DOC_BITS+mmdm_pkg::SUM_W] != '0))
        else $error("matched document word with no matching list");

endmodule
